### rtl/tag_id_rule_filter_assert.svh
// Assertion macros used by the checker file of the tag identifier rule filter.
`ifndef TAG_ID_RULE_FILTER_ASSERT_SVH
`define TAG_ID_RULE_FILTER_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define TRF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define TRF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/trf_pkg.sv
// Package with the types and constants of the tag identifier rule filter.
package trf_pkg;

  // Default sizes handed to the top level parameters.
  localparam int NumRulesDef     = 10;
  localparam int EpcBytesDef     = 64;
  localparam int PatternBytesDef = 32;

  // Fixed field widths of a request.
  localparam int CmdW     = 2;
  localparam int IndexW   = 4;
  localparam int ModeW    = 2;
  localparam int StartW   = 6;
  localparam int LenW     = 6;
  localparam int PatIdxFW = 5;
  localparam int ByteW    = 8;

  // Request commands.
  typedef enum logic [CmdW-1:0] {
    CmdHeader  = 2'd0,
    CmdPattern = 2'd1,
    CmdIdByte  = 2'd2
  } cmd_e;

  // Rule modes; every nonzero mode counts as enabled, only the active one can match.
  localparam logic [ModeW-1:0] ModeOff    = 2'd0;
  localparam logic [ModeW-1:0] ModeActive = 2'd1;

endpackage

### rtl/trf_ram.sv
// Generic simple dual port RAM with one write port and a registered read port.
module trf_ram #(
  parameter int Width = 8,
  parameter int Depth = 320,
  parameter int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/tag_id_rule_filter.sv
// Top level of the tag identifier rule filter.
//
//   Channel  Direction  Handshake                Payload
//   in       request    in_valid_i / in_ready_o  cmd_i .. epc_last_i
//   out      result     out_valid_o / out_ready_i verdict_o
//
// An identifier byte below EpcBytes is taken in StIdle, then StScan reads the
// rules' pattern bytes from the single read port in turn, and StDrain compares the last read.
// Header, pattern and unused requests are taken without leaving StIdle, as is a byte
// past EpcBytes not marked last. A byte marked last goes on to StDecide, which forms the
// verdict once the output register is free, where it waits while new requests are taken.
// Reset disables every rule and clears the tag progress; the pattern RAM is not cleared.
module tag_id_rule_filter #(
  parameter int NumRules     = trf_pkg::NumRulesDef,
  parameter int EpcBytes     = trf_pkg::EpcBytesDef,
  parameter int PatternBytes = trf_pkg::PatternBytesDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [trf_pkg::CmdW-1:0]     cmd_i,
  input  logic [trf_pkg::IndexW-1:0]   rule_index_i,
  input  logic [trf_pkg::ModeW-1:0]    rule_mode_i,
  input  logic [trf_pkg::StartW-1:0]   rule_start_i,
  input  logic [trf_pkg::LenW-1:0]     rule_length_i,
  input  logic [trf_pkg::PatIdxFW-1:0] pattern_index_i,
  input  logic [trf_pkg::ByteW-1:0]    data_byte_i,
  input  logic                        epc_last_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        verdict_o
);

  localparam int RuleW   = (NumRules > 1) ? $clog2(NumRules) : 1;
  localparam int PatIdxW = (PatternBytes > 1) ? $clog2(PatternBytes) : 1;
  localparam int Depth   = NumRules * PatternBytes;
  localparam int AddrW   = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int PosW    = $clog2(EpcBytes + 1);
  localparam int SumW    = ((PosW > trf_pkg::StartW) ? PosW : trf_pkg::StartW) + 2;

  typedef enum logic [1:0] {
    StIdle,
    StScan,
    StDrain,
    StDecide
  } state_e;

  state_e state_q;

  // Rule table in flip-flops; it is small and every entry feeds the verdict.
  logic [trf_pkg::ModeW-1:0]  mode_q  [NumRules];
  logic [trf_pkg::StartW-1:0] start_q [NumRules];
  logic [trf_pkg::LenW-1:0]   len_q   [NumRules];

  // Progress through the current tag.
  logic [NumRules-1:0]        mis_q;
  logic [PosW-1:0]            pos_q;
  logic [PosW-1:0]            cur_pos_q;
  logic [trf_pkg::ByteW-1:0]  val_q;
  logic                       last_q;
  logic [RuleW-1:0]           rule_q;

  // Compare stage behind the RAM read.
  logic                       hit_q;
  logic [RuleW-1:0]           hit_rule_q;

  logic                       out_valid_q;
  logic                       verdict_q;

  logic                       accept;
  logic                       idx_ok;
  logic                       pidx_ok;
  logic [trf_pkg::LenW-1:0]   len_sat;
  logic                       ram_we;
  logic [AddrW-1:0]           ram_waddr;
  logic [AddrW-1:0]           ram_raddr;
  logic [trf_pkg::ByteW-1:0]  ram_rdata;
  logic [SumW-1:0]            offset;
  logic                       in_window;
  logic                       out_free;
  logic                       verdict_calc;

  assign accept   = in_valid_i && in_ready_o;
  assign out_free = !out_valid_q || out_ready_i;

  // Header and pattern writes to slots that do not exist are dropped.
  assign idx_ok  = int'(rule_index_i) < NumRules;
  assign pidx_ok = int'(pattern_index_i) < PatternBytes;
  assign len_sat = (int'(rule_length_i) > PatternBytes) ?
                   trf_pkg::LenW'(PatternBytes) : rule_length_i;

  assign ram_we    = accept && (cmd_i == trf_pkg::CmdPattern) && idx_ok && pidx_ok;
  assign ram_waddr = AddrW'(int'(rule_index_i[RuleW-1:0]) * PatternBytes)
                   + AddrW'(pattern_index_i[PatIdxW-1:0]);

  // The rule under scan covers this byte when it is active and the byte lies inside its window.
  // A zero-length window never covers a byte, so it never records a mismatch.
  assign offset    = SumW'(cur_pos_q) - SumW'(start_q[rule_q]);
  assign in_window = (mode_q[rule_q] == trf_pkg::ModeActive)
                   && (SumW'(cur_pos_q) >= SumW'(start_q[rule_q]))
                   && (offset < SumW'(len_q[rule_q]));
  assign ram_raddr = AddrW'(int'(rule_q) * PatternBytes) + AddrW'(offset[PatIdxW-1:0]);

  trf_ram #(
    .Width (trf_pkg::ByteW),
    .Depth (Depth),
    .AddrW (AddrW)
  ) u_pattern_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (data_byte_i),
    .re_i    ((state_q == StScan) && in_window),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // The tag passes when no rule is enabled, or when some active rule has an empty
  // window or a fully received window without a mismatch.
  always_comb begin
    logic any_en;
    logic any_match;
    any_en    = 1'b0;
    any_match = 1'b0;
    for (int r = 0; r < NumRules; r++) begin
      if (mode_q[r] != trf_pkg::ModeOff) begin
        any_en = 1'b1;
      end
      if (mode_q[r] == trf_pkg::ModeActive) begin
        if (len_q[r] == '0) begin
          any_match = 1'b1;
        end else if (!mis_q[r]
                     && (SumW'(start_q[r]) + SumW'(len_q[r]) <= SumW'(pos_q))) begin
          any_match = 1'b1;
        end
      end
    end
    verdict_calc = !any_en || any_match;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      mis_q       <= '0;
      pos_q       <= '0;
      cur_pos_q   <= '0;
      val_q       <= '0;
      last_q      <= 1'b0;
      rule_q      <= '0;
      hit_q       <= 1'b0;
      hit_rule_q  <= '0;
      out_valid_q <= 1'b0;
      verdict_q   <= 1'b0;
      for (int r = 0; r < NumRules; r++) begin
        mode_q[r]  <= trf_pkg::ModeOff;
        start_q[r] <= '0;
        len_q[r]   <= '0;
      end
    end else begin
      // A verdict formed in this cycle refills the register in the state machine below.
      if (out_valid_q && out_ready_i && (state_q != StDecide)) begin
        out_valid_q <= 1'b0;
      end

      // Compare the pattern byte read in the previous cycle.
      if (hit_q && (ram_rdata != val_q)) begin
        mis_q[hit_rule_q] <= 1'b1;
      end
      hit_q      <= (state_q == StScan) && in_window;
      hit_rule_q <= rule_q;

      unique case (state_q)
        StIdle: begin
          if (accept) begin
            case (cmd_i)
              trf_pkg::CmdHeader: begin
                if (idx_ok) begin
                  mode_q[rule_index_i[RuleW-1:0]]  <= rule_mode_i;
                  start_q[rule_index_i[RuleW-1:0]] <= rule_start_i;
                  len_q[rule_index_i[RuleW-1:0]]   <= len_sat;
                end
              end
              trf_pkg::CmdIdByte: begin
                last_q    <= epc_last_i;
                val_q     <= data_byte_i;
                cur_pos_q <= pos_q;
                if (int'(pos_q) < EpcBytes) begin
                  pos_q   <= pos_q + PosW'(1);
                  rule_q  <= '0;
                  state_q <= StScan;
                end else if (epc_last_i) begin
                  state_q <= StDecide;
                end
              end
              default: begin
              end
            endcase
          end
        end
        StScan: begin
          if (int'(rule_q) == NumRules - 1) begin
            state_q <= StDrain;
          end else begin
            rule_q <= rule_q + RuleW'(1);
          end
        end
        StDrain: begin
          state_q <= last_q ? StDecide : StIdle;
        end
        StDecide: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            verdict_q   <= verdict_calc;
            mis_q       <= '0;
            pos_q       <= '0;
            state_q     <= StIdle;
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = out_valid_q;
  assign verdict_o   = verdict_q;

endmodule

### rtl/tag_id_rule_filter_checker.sv
// Port-level checker for the tag identifier rule filter and its bind statement.
`include "tag_id_rule_filter_assert.svh"

module tag_id_rule_filter_checker (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    in_valid_i,
  input logic                    in_ready_i,
  input logic [trf_pkg::CmdW-1:0] cmd_i,
  input logic                    out_valid_i,
  input logic                    out_ready_i
);

  logic in_acc;
  logic table_write;

  assign in_acc      = in_valid_i && in_ready_i;
  assign table_write = in_acc && (cmd_i != trf_pkg::CmdIdByte);

  // A finished result is held until it is taken.
  `TRF_ASSERT_NEXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i, "result dropped")

  // Table writes leave the block ready in the following cycle.
  `TRF_ASSERT_NEXT(a_write_one_cycle, table_write, in_ready_i, "table write stalled")

  // Table writes never produce a result.
  `TRF_ASSERT_NEXT(a_write_no_result, table_write && !out_valid_i, !out_valid_i,
                   "result from table write")

  // A verdict is formed only while no request is being taken.
  `TRF_ASSERT_NOW(a_verdict_busy, $rose(out_valid_i), !$past(in_ready_i),
                  "verdict while idle")

endmodule

bind tag_id_rule_filter tag_id_rule_filter_checker u_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_i  (in_ready_o),
  .cmd_i       (cmd_i),
  .out_valid_i (out_valid_o),
  .out_ready_i (out_ready_i)
);

### tb/tb_tag_id_rule_filter.sv
// Self-checking testbench for the tag identifier rule filter top level.
`timescale 1ns / 1ps

module tb_tag_id_rule_filter;

  // Sizes of the block under test; the defaults of the package are used.
  localparam int NumRules     = trf_pkg::NumRulesDef;
  localparam int EpcBytes     = trf_pkg::EpcBytesDef;
  localparam int PatternBytes = trf_pkg::PatternBytesDef;

  // The command code that the package leaves without a name does nothing in the block.
  localparam logic [trf_pkg::CmdW-1:0] CmdUnused = 2'd3;

  // Both nonzero modes other than the active one enable a rule that can never match.
  localparam logic [trf_pkg::ModeW-1:0] ModeNoMatch    = 2'd2;
  localparam logic [trf_pkg::ModeW-1:0] ModeNoMatchAlt = 2'd3;

  // Run control. The drain after the last expected verdict covers bytes still in flight.
  localparam int QuietLimit    = 3000;
  localparam int HoldCycles    = 300;
  localparam int DrainCycles   = 4 * (NumRules + 3);
  localparam int RandomItems   = 500;
  localparam int MinRandomTags = 30;

  // One request with every field as the ports carry it.
  typedef struct packed {
    logic [trf_pkg::CmdW-1:0]     cmd;
    logic [trf_pkg::IndexW-1:0]   idx;
    logic [trf_pkg::ModeW-1:0]    mode;
    logic [trf_pkg::StartW-1:0]   start;
    logic [trf_pkg::LenW-1:0]     len;
    logic [trf_pkg::PatIdxFW-1:0] pidx;
    logic [trf_pkg::ByteW-1:0]    data;
    logic                         last;
  } filter_req_t;

  typedef logic [trf_pkg::ByteW-1:0] id_byte_t;
  typedef id_byte_t id_bytes_t[$];

  // Clock, reset and every input start at a known value.
  logic                         clk_i           = 1'b0;
  logic                         rst_ni          = 1'b0;
  logic                         in_valid_i      = 1'b0;
  logic [trf_pkg::CmdW-1:0]     cmd_i           = '0;
  logic [trf_pkg::IndexW-1:0]   rule_index_i    = '0;
  logic [trf_pkg::ModeW-1:0]    rule_mode_i     = '0;
  logic [trf_pkg::StartW-1:0]   rule_start_i    = '0;
  logic [trf_pkg::LenW-1:0]     rule_length_i   = '0;
  logic [trf_pkg::PatIdxFW-1:0] pattern_index_i = '0;
  logic [trf_pkg::ByteW-1:0]    data_byte_i     = '0;
  logic                         epc_last_i      = 1'b0;
  logic                         out_ready_i     = 1'b0;
  logic                         in_ready_o;
  logic                         out_valid_o;
  logic                         verdict_o;

  // Our own copy of the rule table and of the progress through the current tag.
  logic [trf_pkg::ModeW-1:0]  rule_mode_m  [NumRules];
  logic [trf_pkg::StartW-1:0] rule_start_m [NumRules];
  logic [trf_pkg::LenW-1:0]   rule_len_m   [NumRules];
  logic [trf_pkg::ByteW-1:0]  pattern_m    [NumRules][PatternBytes];
  logic [NumRules-1:0]        miss_mask;
  int                         id_pos;

  // Verdicts predicted at request acceptance, waiting for the output channel.
  logic exp_verdict_q[$];

  int err_cnt;         // written by the result checker only
  int verdict_cnt;     // verdicts predicted so far
  int useful_cnt;      // requests that the block does not simply ignore
  bit tx_idle_en = 1'b1;
  bit rx_idle_en = 1'b1;
  int hold_seq;        // bumped by a test to ask the receiver for one long hold

  tag_id_rule_filter DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .cmd_i          (cmd_i),
    .rule_index_i   (rule_index_i),
    .rule_mode_i    (rule_mode_i),
    .rule_start_i   (rule_start_i),
    .rule_length_i  (rule_length_i),
    .pattern_index_i(pattern_index_i),
    .data_byte_i    (data_byte_i),
    .epc_last_i     (epc_last_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .verdict_o      (verdict_o)
  );

  always #1 clk_i = ~clk_i;

  // Idle stretches: mostly short, now and then a long one.
  function automatic int pick_gap();
    if ($urandom_range(0, 9) == 0) begin
      return $urandom_range(12, 60);
    end
    return $urandom_range(1, 3);
  endfunction

  // Every field gets a random value; callers then set the ones their command uses,
  // so fields that a command ignores still toggle freely.
  function automatic filter_req_t rand_req();
    filter_req_t rq;
    rq.cmd   = trf_pkg::CmdW'($urandom_range(0, 3));
    rq.idx   = trf_pkg::IndexW'($urandom);
    rq.mode  = trf_pkg::ModeW'($urandom);
    rq.start = trf_pkg::StartW'($urandom);
    rq.len   = trf_pkg::LenW'($urandom);
    rq.pidx  = trf_pkg::PatIdxFW'($urandom);
    rq.data  = trf_pkg::ByteW'($urandom);
    rq.last  = 1'($urandom);
    return rq;
  endfunction

  // Applies one accepted request to the rule table copy. An identifier byte is
  // compared against every active rule whose window covers its position; the byte
  // marked last turns the mismatch mask into a verdict and starts a new tag.
  function automatic void model_request(filter_req_t rq);
    int  lim;
    bit  any_enabled;
    bit  any_match;
    if (rq.cmd == trf_pkg::CmdHeader) begin
      if (rq.idx < NumRules) begin
        lim = (rq.len > PatternBytes) ? PatternBytes : rq.len;
        rule_mode_m[rq.idx]  = rq.mode;
        rule_start_m[rq.idx] = rq.start;
        rule_len_m[rq.idx]   = trf_pkg::LenW'(lim);
      end
    end else if (rq.cmd == trf_pkg::CmdPattern) begin
      if (rq.idx < NumRules && rq.pidx < PatternBytes) begin
        pattern_m[rq.idx][rq.pidx] = rq.data;
      end
    end else if (rq.cmd == trf_pkg::CmdIdByte) begin
      // Bytes past the identifier size are not compared, but still count as the tag end.
      if (id_pos < EpcBytes) begin
        for (int r = 0; r < NumRules; r++) begin
          if (rule_mode_m[r] == trf_pkg::ModeActive && rule_len_m[r] != 0 &&
              id_pos >= rule_start_m[r] && id_pos - rule_start_m[r] < rule_len_m[r] &&
              pattern_m[r][id_pos - rule_start_m[r]] != rq.data) begin
            miss_mask[r] = 1'b1;
          end
        end
        id_pos++;
      end
      if (rq.last) begin
        any_enabled = 1'b0;
        any_match   = 1'b0;
        for (int r = 0; r < NumRules; r++) begin
          if (rule_mode_m[r] != trf_pkg::ModeOff) begin
            any_enabled = 1'b1;
            // An empty window matches at once; otherwise the whole window must have
            // arrived without a single differing byte.
            if (rule_mode_m[r] == trf_pkg::ModeActive &&
                (rule_len_m[r] == 0 ||
                 (!miss_mask[r] && rule_start_m[r] + rule_len_m[r] <= id_pos))) begin
              any_match = 1'b1;
            end
          end
        end
        exp_verdict_q.push_back(!any_enabled || any_match);
        verdict_cnt++;
        miss_mask = '0;
        id_pos    = 0;
      end
    end
  endfunction

  // Offers one request and returns at the edge where it is taken. Valid stays high
  // between back-to-back requests; a gap lowers it first.
  task automatic send_req(input filter_req_t rq);
    if (tx_idle_en && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat (pick_gap()) @(posedge clk_i);
    end
    cmd_i           <= rq.cmd;
    rule_index_i    <= rq.idx;
    rule_mode_i     <= rq.mode;
    rule_start_i    <= rq.start;
    rule_length_i   <= rq.len;
    pattern_index_i <= rq.pidx;
    data_byte_i     <= rq.data;
    epc_last_i      <= rq.last;
    in_valid_i      <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    model_request(rq);
    if (rq.cmd != CmdUnused && rq.idx < NumRules || rq.cmd == trf_pkg::CmdIdByte) begin
      useful_cnt++;
    end
  endtask

  task automatic send_header(input int idx, input logic [trf_pkg::ModeW-1:0] mode,
                             input int start, input int len);
    filter_req_t rq;
    rq       = rand_req();
    rq.cmd   = trf_pkg::CmdHeader;
    rq.idx   = trf_pkg::IndexW'(idx);
    rq.mode  = mode;
    rq.start = trf_pkg::StartW'(start);
    rq.len   = trf_pkg::LenW'(len);
    send_req(rq);
  endtask

  task automatic send_pattern(input int idx, input int pidx, input id_byte_t val);
    filter_req_t rq;
    rq      = rand_req();
    rq.cmd  = trf_pkg::CmdPattern;
    rq.idx  = trf_pkg::IndexW'(idx);
    rq.pidx = trf_pkg::PatIdxFW'(pidx);
    rq.data = val;
    send_req(rq);
  endtask

  task automatic send_id_byte(input id_byte_t val, input logic last);
    filter_req_t rq;
    rq      = rand_req();
    rq.cmd  = trf_pkg::CmdIdByte;
    rq.data = val;
    rq.last = last;
    send_req(rq);
  endtask

  // A random header: mostly small windows that a tag can satisfy, some wide or
  // overlong ones, some windows ending right at the identifier limit.
  function automatic filter_req_t random_header();
    filter_req_t rq;
    int          roll;
    rq     = rand_req();
    rq.cmd = trf_pkg::CmdHeader;
    rq.idx = trf_pkg::IndexW'(($urandom_range(0, 9) == 0) ? $urandom_range(NumRules, 15)
                                                           : $urandom_range(0, NumRules - 1));
    roll = $urandom_range(0, 99);
    if (roll < 55) begin
      rq.mode = trf_pkg::ModeActive;
    end else if (roll < 80) begin
      rq.mode = trf_pkg::ModeOff;
    end else if (roll < 90) begin
      rq.mode = ModeNoMatch;
    end else begin
      rq.mode = ModeNoMatchAlt;
    end
    roll = $urandom_range(0, 99);
    rq.len = trf_pkg::LenW'((roll < 70) ? $urandom_range(0, 6) :
                            (roll < 90) ? $urandom_range(7, PatternBytes)
                                        : $urandom_range(33, 63));
    roll = $urandom_range(0, 99);
    if (roll < 70) begin
      rq.start = trf_pkg::StartW'($urandom_range(0, 8));
    end else if (roll < 85) begin
      rq.start = trf_pkg::StartW'($urandom_range(0, 63));
    end else begin
      rq.start = trf_pkg::StartW'((rq.len == 0) ? 63 :
                 EpcBytes - ((rq.len > PatternBytes) ? PatternBytes : rq.len));
    end
    return rq;
  endfunction

  // Something the block must handle in passing: a rule rewrite, a pattern rewrite
  // or the unused command.
  task automatic send_noise();
    filter_req_t rq;
    int          roll;
    roll = $urandom_range(0, 2);
    if (roll == 0) begin
      send_req(random_header());
    end else if (roll == 1) begin
      send_pattern($urandom_range(0, 15), $urandom_range(0, 31), id_byte_t'($urandom));
    end else begin
      rq     = rand_req();
      rq.cmd = CmdUnused;
      send_req(rq);
    end
  endtask

  task automatic send_tag(input id_bytes_t body, input int noise_pct);
    for (int i = 0; i < body.size(); i++) begin
      if ($urandom_range(0, 99) < noise_pct) begin
        send_noise();
      end
      send_id_byte(body[i], i == body.size() - 1);
    end
  endtask

  // Random identifier of n bytes; when a rule is given its window is filled from the
  // rule's pattern, and with corrupt one window byte is flipped.
  function automatic id_bytes_t build_tag(input int r, input int n, input bit corrupt);
    id_bytes_t body;
    int        pos;
    for (int i = 0; i < n; i++) begin
      body.push_back(id_byte_t'($urandom));
    end
    if (r >= 0) begin
      for (int k = 0; k < rule_len_m[r]; k++) begin
        pos = rule_start_m[r] + k;
        if (pos < n && pos < EpcBytes) begin
          body[pos] = pattern_m[r][k];
        end
      end
      if (corrupt && rule_len_m[r] != 0) begin
        pos = rule_start_m[r] + int'($urandom_range(0, rule_len_m[r] - 1));
        if (pos < n && pos < EpcBytes) begin
          body[pos] = ~body[pos];
        end
      end
    end
    return body;
  endfunction

  // A tag aimed at one of the active rules: mostly long enough to cover its window,
  // sometimes cut short, sometimes past the identifier size.
  task automatic send_random_tag(input int noise_pct);
    int active_q[$];
    int r;
    int n;
    int w_end;
    int roll;
    for (int i = 0; i < NumRules; i++) begin
      if (rule_mode_m[i] == trf_pkg::ModeActive) begin
        active_q.push_back(i);
      end
    end
    r = -1;
    n = $urandom_range(1, 12);
    if (active_q.size() != 0) begin
      r     = active_q[$urandom_range(0, active_q.size() - 1)];
      w_end = rule_start_m[r] + rule_len_m[r];
      roll  = $urandom_range(0, 99);
      if (roll < 10) begin
        n = (w_end > 1) ? $urandom_range(1, w_end - 1) : 1;
      end else if (roll < 16) begin
        n = $urandom_range(EpcBytes, EpcBytes + 6);
      end else begin
        n = w_end + int'($urandom_range(0, 3));
      end
      if (n == 0) begin
        n = 1;
      end
      if (n > EpcBytes + 6) begin
        n = EpcBytes + 6;
      end
    end
    send_tag(build_tag(r, n, $urandom_range(0, 99) < 20), noise_pct);
  endtask

  // The pattern store has no reset value, so every entry is written once before any
  // rule can read it; the rule table stays disabled meanwhile.
  task automatic load_all_patterns();
    for (int r = 0; r < NumRules; r++) begin
      for (int k = 0; k < PatternBytes; k++) begin
        send_pattern(r, k, id_byte_t'($urandom));
      end
    end
  endtask

  // Hand-picked requests: no rule enabled, an empty window, both never-matching
  // modes, a full match, a wrong byte, a window past the tag end, ignored slots,
  // the unused command, an overlong length and a rule rewrite in the middle of a tag.
  task automatic test_directed_rules();
    id_bytes_t body;
    filter_req_t rq;
    send_tag('{8'h00}, 0);
    send_header(0, trf_pkg::ModeActive, 0, 0);
    send_tag('{8'hFF}, 0);
    send_header(0, ModeNoMatch, 0, 0);
    send_tag('{8'hA5}, 0);
    send_header(0, ModeNoMatchAlt, 5, 9);
    send_tag('{8'h5A}, 0);
    send_header(0, trf_pkg::ModeOff, 0, 0);
    send_header(1, trf_pkg::ModeActive, 1, 2);
    body = '{8'h3C, pattern_m[1][0], pattern_m[1][1]};
    send_tag(body, 0);
    body[2] = ~body[2];
    send_tag(body, 0);
    body = '{8'h3C, pattern_m[1][0]};
    send_tag(body, 0);
    // Slots past the table end are ignored, so rule 1 alone still decides.
    send_header(15, trf_pkg::ModeActive, 0, 0);
    send_pattern(12, 0, 8'h00);
    rq      = rand_req();
    rq.cmd  = CmdUnused;
    rq.last = 1'b1;
    send_req(rq);
    send_id_byte(8'hC3, 1'b0);
    send_header(9, trf_pkg::ModeActive, 63, 63);
    send_id_byte(pattern_m[1][0], 1'b0);
    send_id_byte(pattern_m[1][1], 1'b1);
  endtask

  // Random traffic: reprogramming, pattern rewrites, noise and tags, until enough
  // requests and verdicts have gone through.
  task automatic test_random_traffic();
    int base_items;
    int base_tags;
    int roll;
    base_items = useful_cnt;
    base_tags  = verdict_cnt;
    while (useful_cnt - base_items < RandomItems ||
           verdict_cnt - base_tags < MinRandomTags) begin
      roll = $urandom_range(0, 99);
      if (roll < 3) begin
        for (int r = 0; r < NumRules; r++) begin
          send_header(r, trf_pkg::ModeOff, int'($urandom), int'($urandom));
        end
      end else if (roll < 15) begin
        repeat ($urandom_range(1, 3)) send_req(random_header());
      end else if (roll < 20) begin
        repeat ($urandom_range(1, 4)) send_pattern($urandom_range(0, 15),
                                                   $urandom_range(0, 31),
                                                   id_byte_t'($urandom));
      end else if (roll < 23) begin
        send_noise();
      end else begin
        send_random_tag(4);
      end
    end
  endtask

  // Back-to-back requests with neither side idling.
  task automatic test_no_idle();
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    repeat (12) send_random_tag(0);
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
  endtask

  // The receiver holds off for a long stretch while short tags keep coming, so the
  // output register fills and the input side has to stall.
  task automatic test_output_stall();
    tx_idle_en = 1'b0;
    hold_seq++;
    send_header(0, trf_pkg::ModeActive, 0, 0);
    repeat (8) send_tag(build_tag(-1, $urandom_range(1, 3), 1'b0), 0);
    tx_idle_en = 1'b1;
  endtask

  // Result side: check every accepted verdict, then pick the next ready level.
  int hold_left;
  int hold_seen;
  always @(posedge clk_i) begin : verdict_checker
    logic want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (exp_verdict_q.size() == 0) begin
        $error("verdict: expected none, actual %0b", verdict_o);
        err_cnt++;
      end else begin
        want = exp_verdict_q.pop_front();
        if (verdict_o !== want) begin
          $error("verdict: expected %0b, actual %0b", want, verdict_o);
          err_cnt++;
        end
      end
    end
    if (hold_seen != hold_seq) begin
      hold_seen = hold_seq;
      hold_left = HoldCycles;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else if (rx_idle_en && $urandom_range(0, 4) == 0) begin
      hold_left = pick_gap() - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // Watchdog: ends the run when neither channel moves for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QuietLimit) begin
      @(posedge clk_i);
      if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("Mismatches found");
    $finish;
  end

  initial begin
    miss_mask = '0;
    id_pos    = 0;
    for (int r = 0; r < NumRules; r++) begin
      rule_mode_m[r]  = trf_pkg::ModeOff;
      rule_start_m[r] = '0;
      rule_len_m[r]   = '0;
    end
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    load_all_patterns();
    test_directed_rules();
    test_no_idle();
    test_output_stall();
    test_random_traffic();

    in_valid_i <= 1'b0;
    while (exp_verdict_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (err_cnt == 0 && exp_verdict_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
